FILE: hw/rtl/cpg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circle point generator package
// Widths, the step record type and the octant point arithmetic.
// ----------------------------------------------------------------------------
package cpg_pkg;

  localparam int RADIUS_BITS = 9;
  localparam int CENTRE_W    = 10;
  localparam int COORD_W     = 12;
  localparam int OFF_W       = RADIUS_BITS + 1;
  localparam int DEC_W       = RADIUS_BITS + 5;
  localparam int CALC_W      = (OFF_W > COORD_W) ? OFF_W : COORD_W;
  localparam int COLOR_W     = 4;
  localparam int PT_IDX_W    = 3;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_ADVANCE = 1'b1;

  localparam logic [PT_IDX_W-1:0] PT_IDX_LAST = PT_IDX_W'(7);
  localparam logic [COLOR_W-1:0]  COLOR_LAST  = COLOR_W'(14);

  localparam logic [COLOR_W-1:0] OCT_COLOR [8] = '{
    COLOR_W'(1), COLOR_W'(2), COLOR_W'(3), COLOR_W'(4),
    COLOR_W'(5), COLOR_W'(6), COLOR_W'(15), COLOR_W'(14)
  };

  typedef logic signed [OFF_W-1:0] off_t;

  // One circle position, as the back end needs it to emit eight points.
  typedef struct packed {
    logic [CENTRE_W-1:0] cx;
    logic [CENTRE_W-1:0] cy;
    off_t                xo;
    off_t                yo;
    logic                fin;
  } step_t;

  // Centre plus or minus a signed offset, wrapped to the coordinate width.
  function automatic logic [COORD_W-1:0] coord(logic [CENTRE_W-1:0] c, off_t o, logic neg);
    logic [CALC_W-1:0] ce;
    logic [CALC_W-1:0] oe;
    logic [CALC_W-1:0] s;
    ce = CALC_W'(c);
    oe = CALC_W'(signed'(o));
    s  = neg ? (ce - oe) : (ce + oe);
    return s[COORD_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/circle_point_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circle point generator unit
// Midpoint circle rasterizer producing eight symmetric points per step.
// ----------------------------------------------------------------------------
// The first point of a word reaches the output through the step queue and
// the back end's registered output stage.
// Throughput: a start or a live advance word yields eight points at one point
// per cycle while out_stall is low; the back end's single output register
// paces such words through the queue. An advance with no circle queues nothing.
// Reset (synchronous, rst_n low) clears the circle state, the queue and the
// output stage.
// ----------------------------------------------------------------------------
module circle_point_generator_unit import cpg_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_action,
  input  logic [CENTRE_W-1:0]       in_center_x,
  input  logic [CENTRE_W-1:0]       in_center_y,
  input  logic [RADIUS_BITS-1:0]    in_radius,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] out_pixel_x,
  output logic signed [COORD_W-1:0] out_pixel_y,
  output logic [COLOR_W-1:0]        out_color,
  output logic                      out_last,
  output logic                      out_finished
);

  // The front end updates the circle state in the cycle a word is accepted
  // and drops a step record into the queue. Words stall only when the queue
  // is full, so the front end runs ahead while the back end still drains
  // points of earlier steps.
  logic  accept;
  logic  push, pop;
  logic  q_not_empty, q_full;
  step_t wr_rec, rd_rec;
  logic [COORD_W-1:0] px, py;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  cpg_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .action   (in_action),
    .center_x (in_center_x),
    .center_y (in_center_y),
    .radius   (in_radius),
    .push     (push),
    .rec      (wr_rec)
  );

  cpg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_rec    (wr_rec),
    .pop       (pop),
    .rd_rec    (rd_rec),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  // The back end walks the eight octants of the head record, advancing only
  // when its output register is free, and retires the record on the eighth.
  cpg_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .rec          (rd_rec),
    .rec_valid    (q_not_empty),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_pixel_x  (px),
    .out_pixel_y  (py),
    .out_color    (out_color),
    .out_last     (out_last),
    .out_finished (out_finished)
  );

  assign out_pixel_x = signed'(px);
  assign out_pixel_y = signed'(py);

endmodule

FILE: hw/rtl/cpg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circle point generator front end
// Accepts start and advance words, runs the midpoint decision update and
// queues one step record for every word that produces points.
// ----------------------------------------------------------------------------
module cpg_front import cpg_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  logic                   action,
  input  logic [CENTRE_W-1:0]    center_x,
  input  logic [CENTRE_W-1:0]    center_y,
  input  logic [RADIUS_BITS-1:0] radius,
  output logic                   push,
  output step_t                  rec
);

  logic                    active_r, active_nxt;
  off_t                    x_r, x_nxt;
  off_t                    y_r, y_nxt;
  logic signed [DEC_W-1:0] dec_r, dec_nxt;
  logic [CENTRE_W-1:0]     cx_r, cx_nxt;
  logic [CENTRE_W-1:0]     cy_r, cy_nxt;
  logic signed [DEC_W-1:0] x4, y4;
  logic                    done;

  always_comb begin
    active_nxt = active_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    dec_nxt    = dec_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    push       = 1'b0;
    done       = 1'b0;
    x4         = DEC_W'(x_r) <<< 2;
    y4         = DEC_W'(y_r) <<< 2;
    if (accept) begin
      if (action == ACT_START) begin
        cx_nxt     = center_x;
        cy_nxt     = center_y;
        x_nxt      = '0;
        y_nxt      = OFF_W'(radius);
        dec_nxt    = DEC_W'(3) - (DEC_W'(radius) <<< 1);
        active_nxt = 1'b1;
        push       = 1'b1;
      end else if (active_r) begin
        if (dec_r <= 0) begin
          dec_nxt = dec_r + x4 + DEC_W'(6);
        end else begin
          dec_nxt = dec_r + x4 - y4 + DEC_W'(10);
          y_nxt   = y_r - OFF_W'(1);
        end
        x_nxt = x_r + OFF_W'(1);
        done  = x_nxt > y_nxt;
        if (done) begin
          active_nxt = 1'b0;
        end
        push = 1'b1;
      end
    end
    rec.cx  = cx_nxt;
    rec.cy  = cy_nxt;
    rec.xo  = x_nxt;
    rec.yo  = y_nxt;
    rec.fin = done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      x_r      <= '0;
      y_r      <= '0;
      dec_r    <= '0;
      cx_r     <= '0;
      cy_r     <= '0;
    end else begin
      active_r <= active_nxt;
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      dec_r    <= dec_nxt;
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
    end
  end

  // A finishing step leaves no circle in progress.
  a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (push && rec.fin) |=> !active_r)
    else $error("circle still active after finishing step");

endmodule

FILE: hw/rtl/cpg_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circle point generator step queue
// Short FIFO of step records between the front and back ends.
// ----------------------------------------------------------------------------
module cpg_queue import cpg_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  step_t wr_rec,
  input  logic  pop,
  output step_t rd_rec,
  output logic  not_empty,
  output logic  full
);

  step_t              mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == Q_CNT_W'(Q_DEPTH));
  assign rd_rec    = mem_r[rd_ptr_r];

  function automatic logic [Q_PTR_W-1:0] ptr_inc(logic [Q_PTR_W-1:0] p);
    return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + Q_PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + Q_CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - Q_CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("step queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("step queue read while empty");

endmodule

FILE: hw/rtl/cpg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circle point generator back end
// Expands each queued step into its eight octant points, one per cycle while
// out_stall is low, through a registered output stage.
// ----------------------------------------------------------------------------
module cpg_back import cpg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  step_t              rec,
  input  logic               rec_valid,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COORD_W-1:0] out_pixel_x,
  output logic [COORD_W-1:0] out_pixel_y,
  output logic [COLOR_W-1:0] out_color,
  output logic               out_last,
  output logic               out_finished
);

  logic [PT_IDX_W-1:0] idx_r;
  logic                valid_r;
  logic [COORD_W-1:0]  px_r, py_r, px_nxt, py_nxt;
  logic [COLOR_W-1:0]  color_r;
  logic                last_r, fin_r;
  logic                load, take;
  logic                swap, neg_a, neg_b;
  off_t                a, b;

  assign load = !valid_r || !out_stall;
  assign take = rec_valid && load;
  assign pop  = take && (idx_r == PT_IDX_LAST);

  // Upper half of the point order swaps x and y; the sign pattern follows
  // the octant order of the emission sequence.
  always_comb begin
    swap   = idx_r[2];
    neg_a  = idx_r[1];
    neg_b  = idx_r[1] ^ idx_r[0];
    a      = swap ? rec.yo : rec.xo;
    b      = swap ? rec.xo : rec.yo;
    px_nxt = coord(rec.cx, a, neg_a);
    py_nxt = coord(rec.cy, b, neg_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (load) begin
        valid_r <= rec_valid;
      end
      if (take) begin
        idx_r <= idx_r + PT_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      px_r    <= px_nxt;
      py_r    <= py_nxt;
      color_r <= OCT_COLOR[idx_r];
      last_r  <= (idx_r == PT_IDX_LAST);
      fin_r   <= rec.fin;
    end
  end

  assign out_valid    = valid_r;
  assign out_pixel_x  = px_r;
  assign out_pixel_y  = py_r;
  assign out_color    = color_r;
  assign out_last     = last_r;
  assign out_finished = fin_r;

  a_last_color: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_color == COLOR_LAST))
    else $error("last point of a step carries the wrong octant color");

endmodule
